// ----- src/assert_macros.svh -----
// Assertion macros shared by the framer RTL.
// Each macro takes a label, clock, active-low reset, two expressions and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SCPF_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Next-cycle implication.
`define SCPF_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ----- src/scpf_pkg.sv -----
// Shared types, constants and helpers for the shift cipher packet framer.
// Used by every module of the block; depends on nothing.
package scpf_pkg;

  localparam int KEY_DEPTH_DEF   = 128;
  localparam int MAX_PACKETS_DEF = 99;

  localparam int DATA_PER_PACKET = 18;
  localparam int HEADER_BYTES    = 7;
  localparam int PACKET_SPAN     = 26;
  localparam int FILL_MAX        = 31;
  localparam int LETTER_A        = 97;
  localparam int LETTER_Z        = 122;
  localparam int ASCII_ZERO      = 48;
  localparam int ALPHABET        = 26;

  // Biases that keep the shift sum non-negative before the modulo.
  localparam int ENC_BIAS = 4 * ALPHABET - LETTER_A;
  localparam int DEC_BIAS = 2 * ALPHABET;

  // Reciprocal multiplies for the constant divisions.
  localparam int MOD26_MUL     = 79;
  localparam int MOD26_SHIFT   = 11;
  localparam int RECIP18_MUL   = 3641;
  localparam int RECIP18_SHIFT = 16;
  localparam int RECIP10_MUL   = 205;
  localparam int RECIP10_SHIFT = 11;

  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_ADDR_W-1:0] CFG_MODE           = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LENGTH     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MESSAGE_LENGTH = 2'd2;

  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // Byte positions within a framed packet as the back end walks them.
  localparam logic [2:0] POS_CNT2  = 3'd0;
  localparam logic [2:0] POS_CNT1  = 3'd1;
  localparam logic [2:0] POS_CNT0  = 3'd2;
  localparam logic [2:0] POS_FIRST = 3'd3;
  localparam logic [2:0] POS_PN2   = 3'd4;
  localparam logic [2:0] POS_PN1   = 3'd5;
  localparam logic [2:0] POS_PN0   = 3'd6;
  localparam logic [2:0] POS_DATA  = 3'd7;

  localparam logic [11:0] BCD_ONE = 12'h001;

  typedef struct packed {
    logic        header;
    logic [7:0]  first_byte;
    logic [11:0] pnum_bcd;
    logic [7:0]  data;
    logic        pend;
    logic        mend;
  } scpf_entry_t;

  function automatic logic [11:0] bcd3_inc(input logic [11:0] v);
    logic [11:0] r;
    logic        carry;
    r     = v;
    carry = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (carry) begin
        if (r[4*i +: 4] == 4'd9) begin
          r[4*i +: 4] = 4'd0;
        end else begin
          r[4*i +: 4] = r[4*i +: 4] + 4'd1;
          carry       = 1'b0;
        end
      end
    end
    return r;
  endfunction

endpackage

// ----- src/shift_cipher_packet_framer_top.sv -----
// Top level of the shift cipher packet framer: configuration registers and wiring.
// Depends on scpf_pkg, scpf_front, scpf_queue and scpf_back.
//
//   port group   direction  handshake          payload
//   in_*         input      in_push / in_full  func, key slot and shift, data byte, done flags
//   out_*        output     out_empty / out_pop byte, packet end, message end, run last
//   cfg_*        input      cfg_we             cfg_addr, cfg_wdata
//
// One input item is taken per cycle while in_full is low; a data byte passes the front stage
// register and the queue to the output register. A packet-opening byte yields eight results,
// one per cycle while out_pop keeps pace, so framing sustains about 25 outputs per 18 inputs.
// The key table read sets the front stage: registered, ready in the cycle after acceptance.
// Reset is synchronous; the key table holds no reset and needs no clearing pass.
// A stall on the output fills the queue, after which in_full rises until room returns.

module shift_cipher_packet_framer_top #(
  parameter int KEY_DEPTH   = scpf_pkg::KEY_DEPTH_DEF,
  parameter int MAX_PACKETS = scpf_pkg::MAX_PACKETS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_func,
  input  logic [6:0]                      in_key_slot,
  input  logic [4:0]                      in_key_shift,
  input  logic [7:0]                      in_data_byte,
  input  logic                            in_packet_done,
  input  logic                            in_message_done,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [7:0]                      out_byte,
  output logic                            out_packet_end,
  output logic                            out_message_end,
  output logic                            out_run_last,
  input  logic                            cfg_we,
  input  logic [scpf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [scpf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic        mode_r;
  logic [7:0]  key_length_r;
  logic [10:0] message_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= scpf_pkg::MODE_ENCRYPT;
      key_length_r     <= 8'd1;
      message_length_r <= 11'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        scpf_pkg::CFG_MODE:           mode_r           <= cfg_wdata[0];
        scpf_pkg::CFG_KEY_LENGTH:     key_length_r     <= cfg_wdata[7:0];
        scpf_pkg::CFG_MESSAGE_LENGTH: message_length_r <= cfg_wdata[10:0];
        default: begin
        end
      endcase
    end
  end

  logic                  q_push, q_full, q_pop, q_empty;
  scpf_pkg::scpf_entry_t q_wr_entry, q_head;

  scpf_front #(
    .KEY_DEPTH   (KEY_DEPTH),
    .MAX_PACKETS (MAX_PACKETS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_func            (in_func),
    .in_key_slot        (in_key_slot),
    .in_key_shift       (in_key_shift),
    .in_data_byte       (in_data_byte),
    .in_packet_done     (in_packet_done),
    .in_message_done    (in_message_done),
    .cfg_mode           (mode_r),
    .cfg_key_length     (key_length_r),
    .cfg_message_length (message_length_r),
    .q_push             (q_push),
    .q_entry            (q_wr_entry),
    .q_full             (q_full)
  );

  scpf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  scpf_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_message_length (message_length_r),
    .q_head             (q_head),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_byte           (out_byte),
    .out_packet_end     (out_packet_end),
    .out_message_end    (out_message_end),
    .out_run_last       (out_run_last)
  );

endmodule

// ----- src/scpf_front.sv -----
// Front end: accepts items, loads the key table, classifies bytes and ciphers them.
// Depends on scpf_pkg and assert_macros.svh; feeds scpf_queue.
`include "assert_macros.svh"

module scpf_front #(
  parameter int KEY_DEPTH   = scpf_pkg::KEY_DEPTH_DEF,
  parameter int MAX_PACKETS = scpf_pkg::MAX_PACKETS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_func,
  input  logic [6:0]            in_key_slot,
  input  logic [4:0]            in_key_shift,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_packet_done,
  input  logic                  in_message_done,
  input  logic                  cfg_mode,
  input  logic [7:0]            cfg_key_length,
  input  logic [10:0]           cfg_message_length,
  output logic                  q_push,
  output scpf_pkg::scpf_entry_t q_entry,
  input  logic                  q_full
);

  localparam int AW  = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int LW  = ($clog2(KEY_DEPTH + 1) > 8) ? $clog2(KEY_DEPTH + 1) : 8;
  localparam int PNW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS + 1) : 1;

  logic [4:0] key_mem [KEY_DEPTH];
  logic [4:0] key_rd_r;

  logic [AW-1:0]  kpos_r, kpos_nxt;
  logic [10:0]    bytes_r, bytes_nxt;
  logic [4:0]     fill_r, fill_nxt;
  logic [PNW-1:0] pnum_r, pnum_nxt;
  logic [11:0]    pbcd_r, pbcd_nxt;
  logic [7:0]     fcb_r;

  logic        stg_v_r, stg_v_nxt;
  logic        stg_fwd_r, stg_hdr_r, stg_first_r, stg_pend_r, stg_mend_r;
  logic [7:0]  stg_data_r;
  logic [11:0] stg_pbcd_r;

  logic          accept, is_data, is_enc, slot_ok, use_key, stg_ld, stg_move;
  logic [LW-1:0] klen, pos_inc;
  logic [AW-1:0] pos_cur, pos_adv;
  logic [10:0]   mlen;
  logic [11:0]   bd_inc;
  logic [5:0]    fill_inc;
  logic          last, emit_enc, full_pkt, pn_last, kept;
  logic          hdr_ld, first_ld, pend_ld, mend_ld;

  assign accept   = in_push && !in_full;
  assign in_full  = stg_v_r && q_full;
  assign stg_move = stg_v_r && !q_full;
  assign q_push   = stg_move;
  assign is_data  = (in_func == scpf_pkg::FUNC_DATA);
  assign is_enc   = (cfg_mode == scpf_pkg::MODE_ENCRYPT);
  assign slot_ok  = (32'(in_key_slot) < KEY_DEPTH);

  always_comb begin
    klen = LW'(cfg_key_length);
    if (klen == '0) begin
      klen = LW'(1);
    end
    if (klen > LW'(KEY_DEPTH)) begin
      klen = LW'(KEY_DEPTH);
    end
  end

  assign pos_cur = (LW'(kpos_r) >= klen) ? '0 : kpos_r;
  assign pos_inc = LW'(pos_cur) + LW'(1);
  assign pos_adv = (pos_inc >= klen) ? '0 : AW'(pos_inc);

  assign mlen     = (cfg_message_length == '0) ? 11'd1 : cfg_message_length;
  assign bd_inc   = {1'b0, bytes_r} + 12'd1;
  assign last     = (bd_inc >= {1'b0, mlen});
  assign emit_enc = (pnum_r < PNW'(MAX_PACKETS));
  assign fill_inc = {1'b0, fill_r} + 6'd1;
  assign full_pkt = (fill_inc >= 6'(scpf_pkg::DATA_PER_PACKET));
  assign pn_last  = (({1'b0, pnum_r} + (PNW+1)'(1)) >= (PNW+1)'(MAX_PACKETS));

  assign kept = (fill_r >= 5'(scpf_pkg::HEADER_BYTES)) &&
                (fill_r < 5'(scpf_pkg::PACKET_SPAN - 1)) &&
                (in_data_byte >= 8'(scpf_pkg::LETTER_A)) &&
                (in_data_byte <= 8'(scpf_pkg::LETTER_Z));

  assign use_key  = accept && is_data && (is_enc || kept);
  assign stg_ld   = accept && is_data && (is_enc ? emit_enc : kept);
  assign hdr_ld   = is_enc && (fill_r == '0);
  assign first_ld = is_enc && (bytes_r == '0);
  assign pend_ld  = is_enc && (full_pkt || last);
  assign mend_ld  = is_enc ? (last || (full_pkt && pn_last)) : in_message_done;

  always_comb begin
    kpos_nxt  = kpos_r;
    bytes_nxt = bytes_r;
    fill_nxt  = fill_r;
    pnum_nxt  = pnum_r;
    pbcd_nxt  = pbcd_r;
    if (accept && is_data) begin
      if (use_key) begin
        kpos_nxt = pos_adv;
      end
      if (is_enc) begin
        if (emit_enc) begin
          if (full_pkt) begin
            fill_nxt = '0;
            pnum_nxt = pnum_r + PNW'(1);
            pbcd_nxt = scpf_pkg::bcd3_inc(pbcd_r);
          end else begin
            fill_nxt = fill_inc[4:0];
          end
        end
        if (last) begin
          bytes_nxt = '0;
          fill_nxt  = '0;
          pnum_nxt  = '0;
          pbcd_nxt  = scpf_pkg::BCD_ONE;
          kpos_nxt  = '0;
        end else begin
          bytes_nxt = bd_inc[10:0];
        end
      end else begin
        if (in_packet_done || in_message_done) begin
          fill_nxt = '0;
        end else if (fill_r < 5'(scpf_pkg::FILL_MAX)) begin
          fill_nxt = fill_r + 5'd1;
        end
        if (in_message_done) begin
          kpos_nxt = '0;
        end
      end
    end
  end

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (stg_ld) begin
      stg_v_nxt = 1'b1;
    end else if (stg_move) begin
      stg_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kpos_r  <= '0;
      bytes_r <= '0;
      fill_r  <= '0;
      pnum_r  <= '0;
      pbcd_r  <= scpf_pkg::BCD_ONE;
      fcb_r   <= '0;
      stg_v_r <= 1'b0;
    end else begin
      kpos_r  <= kpos_nxt;
      bytes_r <= bytes_nxt;
      fill_r  <= fill_nxt;
      pnum_r  <= pnum_nxt;
      pbcd_r  <= pbcd_nxt;
      stg_v_r <= stg_v_nxt;
      if (stg_move && stg_first_r) begin
        fcb_r <= q_entry.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_data && slot_ok) begin
      key_mem[AW'(in_key_slot)] <= in_key_shift;
    end
    if (use_key) begin
      key_rd_r <= key_mem[pos_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_ld) begin
      stg_fwd_r   <= is_enc;
      stg_data_r  <= in_data_byte;
      stg_hdr_r   <= hdr_ld;
      stg_first_r <= first_ld;
      stg_pend_r  <= pend_ld;
      stg_mend_r  <= mend_ld;
      stg_pbcd_r  <= pbcd_r;
    end
  end

  logic [8:0]  sum;
  logic [14:0] quo_prod;
  logic [3:0]  quo;
  logic [8:0]  rem;
  logic [7:0]  cipher;

  always_comb begin
    if (stg_fwd_r) begin
      sum = 9'(stg_data_r) + 9'(key_rd_r) + 9'(scpf_pkg::ENC_BIAS);
    end else begin
      sum = 9'(stg_data_r) - 9'(scpf_pkg::LETTER_A) + 9'(scpf_pkg::DEC_BIAS) - 9'(key_rd_r);
    end
    quo_prod = 15'(sum) * 15'(scpf_pkg::MOD26_MUL);
    quo      = 4'(quo_prod >> scpf_pkg::MOD26_SHIFT);
    rem      = sum - 9'(quo) * 9'(scpf_pkg::ALPHABET);
    cipher   = 8'(rem) + 8'(scpf_pkg::LETTER_A);
  end

  always_comb begin
    q_entry.header     = stg_hdr_r;
    q_entry.first_byte = stg_first_r ? cipher : fcb_r;
    q_entry.pnum_bcd   = stg_pbcd_r;
    q_entry.data       = cipher;
    q_entry.pend       = stg_pend_r;
    q_entry.mend       = stg_mend_r;
  end

  `SCPF_ASSERT_NEXT(a_stage_holds, clk, rst_n, stg_v_r && q_full,
                    stg_v_r && $stable(stg_data_r) && $stable(key_rd_r),
                    "stalled stage item changed")
  `SCPF_ASSERT_IMPL(a_header_first, clk, rst_n, stg_v_r && stg_first_r, stg_hdr_r,
                    "first byte of a message without a packet header")

endmodule

// ----- src/scpf_queue.sv -----
// Short queue of ciphered items between the front and back ends.
// Depends on scpf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scpf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  scpf_pkg::scpf_entry_t wr_entry,
  output logic                  full,
  input  logic                  pop,
  output scpf_pkg::scpf_entry_t head,
  output logic                  empty
);

  localparam int PW = $clog2(scpf_pkg::QUEUE_DEPTH);

  scpf_pkg::scpf_entry_t slots [scpf_pkg::QUEUE_DEPTH];

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == (PW+1)'(scpf_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + (PW+1)'(do_push) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr_r] <= wr_entry;
    end
  end

  `SCPF_ASSERT_IMPL(a_no_overflow, clk, rst_n, push, !full, "push into a full queue")
  `SCPF_ASSERT_IMPL(a_no_underflow, clk, rst_n, pop, !empty, "pop from an empty queue")

endmodule

// ----- src/scpf_back.sv -----
// Back end: expands queued items into header and cipher bytes and holds the output.
// Depends on scpf_pkg and assert_macros.svh; reads scpf_queue.
`include "assert_macros.svh"

module scpf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [10:0]           cfg_message_length,
  input  scpf_pkg::scpf_entry_t q_head,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [7:0]            out_byte,
  output logic                  out_packet_end,
  output logic                  out_message_end,
  output logic                  out_run_last
);

  logic [10:0] mlen;
  logic [11:0] mlen_round;
  logic [22:0] cnt_prod;
  logic [6:0]  cnt_r;
  logic        cnt_hund;
  logic [6:0]  cnt_rem;
  logic [14:0] tens_prod;
  logic [3:0]  cnt_tens, cnt_ones;
  logic [11:0] cnt_dig_r;

  assign mlen       = (cfg_message_length == '0) ? 11'd1 : cfg_message_length;
  assign mlen_round = 12'(mlen) + 12'(scpf_pkg::DATA_PER_PACKET - 1);
  assign cnt_prod   = 23'(mlen_round) * 23'(scpf_pkg::RECIP18_MUL);

  always_comb begin
    cnt_hund  = (cnt_r >= 7'd100);
    cnt_rem   = cnt_hund ? cnt_r - 7'd100 : cnt_r;
    tens_prod = 15'(cnt_rem) * 15'(scpf_pkg::RECIP10_MUL);
    cnt_tens  = 4'(tens_prod >> scpf_pkg::RECIP10_SHIFT);
    cnt_ones  = 4'(cnt_rem - 7'(cnt_tens) * 7'd10);
  end

  always_ff @(posedge clk) begin
    cnt_r     <= 7'(cnt_prod >> scpf_pkg::RECIP18_SHIFT);
    cnt_dig_r <= {3'd0, cnt_hund, cnt_tens, cnt_ones};
  end

  logic [2:0] idx_r, idx_nxt, cur;
  logic       out_v_r, out_v_nxt, load;
  logic [7:0] byte_sel;

  assign cur       = q_head.header ? idx_r : scpf_pkg::POS_DATA;
  assign load      = !q_empty && (!out_v_r || out_pop);
  assign q_pop     = load && (cur == scpf_pkg::POS_DATA);
  assign out_empty = !out_v_r;

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = (cur == scpf_pkg::POS_DATA) ? scpf_pkg::POS_CNT2 : cur + 3'd1;
    end
    out_v_nxt = out_v_r;
    if (load) begin
      out_v_nxt = 1'b1;
    end else if (out_pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_comb begin
    unique case (cur)
      scpf_pkg::POS_CNT2:  byte_sel = 8'(scpf_pkg::ASCII_ZERO) + 8'(cnt_dig_r[11:8]);
      scpf_pkg::POS_CNT1:  byte_sel = 8'(scpf_pkg::ASCII_ZERO) + 8'(cnt_dig_r[7:4]);
      scpf_pkg::POS_CNT0:  byte_sel = 8'(scpf_pkg::ASCII_ZERO) + 8'(cnt_dig_r[3:0]);
      scpf_pkg::POS_FIRST: byte_sel = q_head.first_byte;
      scpf_pkg::POS_PN2:   byte_sel = 8'(scpf_pkg::ASCII_ZERO) + 8'(q_head.pnum_bcd[11:8]);
      scpf_pkg::POS_PN1:   byte_sel = 8'(scpf_pkg::ASCII_ZERO) + 8'(q_head.pnum_bcd[7:4]);
      scpf_pkg::POS_PN0:   byte_sel = 8'(scpf_pkg::ASCII_ZERO) + 8'(q_head.pnum_bcd[3:0]);
      scpf_pkg::POS_DATA:  byte_sel = q_head.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= scpf_pkg::POS_CNT2;
      out_v_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte        <= byte_sel;
      out_packet_end  <= (cur == scpf_pkg::POS_DATA) && q_head.pend;
      out_message_end <= (cur == scpf_pkg::POS_DATA) && q_head.mend;
      out_run_last    <= (cur == scpf_pkg::POS_DATA);
    end
  end

  `SCPF_ASSERT_IMPL(a_header_needs_head, clk, rst_n, idx_r != scpf_pkg::POS_CNT2, !q_empty,
                    "queue head left in the middle of a header")

endmodule
